FILE: rtl/rpe_pkg.sv
package rpe_pkg;

    localparam int MAX_ROW_WIDTH_DEF = 1024;

    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int SUM_W   = 10;
    localparam int RW_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    // Reciprocal of three scaled by 2^11; exact floor for sums up to 765.
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GREYSCALE = 3'd0,
        REG_MIRROR    = 3'd1,
        REG_NEGATE    = 3'd2,
        REG_FLATTEN   = 3'd3,
        REG_CONTRAST  = 3'd4,
        REG_ROW_WIDTH = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic       greyscale_on;
        logic [2:0] negate_mask;
        logic [2:0] flatten_mask;
        logic       contrast_on;
    } fx_cfg_t;

    function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] sum);
        logic [2*SUM_W-1:0] prod;
        prod = (2*SUM_W)'(sum) * (2*SUM_W)'(DIV3_MUL);
        return CH_W'(prod >> DIV3_SHIFT);
    endfunction

endpackage

FILE: rtl/rgb_pixel_effects_with_row_mirror.sv
// Output path: line store read register, then output register; pixels come out one row late.
// Throughput: one item per cycle; pixel items write the line store and any item reads it while
// a row is pending; the input stalls only while the read stage and output word are both held.
// Reset clears the row counters, bank select and output valid, and loads register defaults.
// The line store is not cleared; only written entries are ever read back.
module rgb_pixel_effects_with_row_mirror #(
    parameter int MAX_ROW_WIDTH = rpe_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpe_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [rpe_pkg::CH_W-1:0]          s_in_red,
    input  logic [rpe_pkg::CH_W-1:0]          s_in_green,
    input  logic [rpe_pkg::CH_W-1:0]          s_in_blue,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rpe_pkg::CH_W-1:0]          m_out_red,
    output logic [rpe_pkg::CH_W-1:0]          m_out_green,
    output logic [rpe_pkg::CH_W-1:0]          m_out_blue,
    output logic                              m_row_end
);

    localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
    localparam int CNT_W  = $clog2(MAX_ROW_WIDTH + 1);
    localparam int ADDR_W = COL_W + 1;

    // Configuration registers
    logic                       greyscale_reg;
    logic                       mirror_reg;
    logic [2:0]                 negate_reg;
    logic [2:0]                 flatten_reg;
    logic                       contrast_reg;
    logic [rpe_pkg::RW_W-1:0]   row_width_reg;
    rpe_pkg::fx_cfg_t           fx_cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            greyscale_reg <= 1'b0;
            mirror_reg    <= 1'b0;
            negate_reg    <= '0;
            flatten_reg   <= '0;
            contrast_reg  <= 1'b0;
            row_width_reg <= rpe_pkg::ROW_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (rpe_pkg::cfg_reg_t'(cfg_index))
                rpe_pkg::REG_GREYSCALE: greyscale_reg <= cfg_data[0];
                rpe_pkg::REG_MIRROR:    mirror_reg    <= cfg_data[0];
                rpe_pkg::REG_NEGATE:    negate_reg    <= cfg_data[2:0];
                rpe_pkg::REG_FLATTEN:   flatten_reg   <= cfg_data[2:0];
                rpe_pkg::REG_CONTRAST:  contrast_reg  <= cfg_data[0];
                rpe_pkg::REG_ROW_WIDTH: row_width_reg <= cfg_data[rpe_pkg::RW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign fx_cfg.greyscale_on = greyscale_reg;
    assign fx_cfg.negate_mask  = negate_reg;
    assign fx_cfg.flatten_mask = flatten_reg;
    assign fx_cfg.contrast_on  = contrast_reg;

    logic [rpe_pkg::PIX_W-1:0] fx_pixel;

    rpe_pixel_fx u_fx (
        .cfg   (fx_cfg),
        .red   (s_in_red),
        .green (s_in_green),
        .blue  (s_in_blue),
        .pixel (fx_pixel)
    );

    // Row bookkeeping
    logic [COL_W-1:0] wcol_reg, wcol_next;
    logic             wbank_reg, wbank_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic [COL_W-1:0] rcol_reg, rcol_next;

    logic             p1_valid_reg, p1_valid_next;
    logic             p1_last_reg;
    logic             m_valid_reg;
    logic [rpe_pkg::PIX_W-1:0] m_pix_reg;
    logic             m_last_reg;

    logic             accept;
    logic             out_adv;
    logic [CNT_W-1:0] eff_width;
    logic             drain_close;
    logic [CNT_W-1:0] pend_eff;
    logic [COL_W-1:0] rcol_eff;
    logic             rbank;
    logic             emit;
    logic             last;
    logic [CNT_W-1:0] idx_full;
    logic [COL_W-1:0] rd_idx;
    logic [CNT_W-1:0] wcol_inc;
    logic             wr_en;
    logic [rpe_pkg::PIX_W-1:0] rd_data;

    assign out_adv = !m_valid_reg || m_ready;
    assign s_ready = out_adv || !p1_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (row_width_reg == '0) begin
            eff_width = CNT_W'(1);
        end else if (32'(row_width_reg) > 32'(MAX_ROW_WIDTH)) begin
            eff_width = CNT_W'(MAX_ROW_WIDTH);
        end else begin
            eff_width = CNT_W'(row_width_reg);
        end
    end

    assign wcol_inc = CNT_W'(wcol_reg) + CNT_W'(1);

    // A drain with nothing pending closes the partial row first, then reads from it.
    assign drain_close = (s_mode == rpe_pkg::MODE_DRAIN) && (pend_reg == '0)
                         && (wcol_reg != '0);
    assign pend_eff = drain_close ? CNT_W'(wcol_reg) : pend_reg;
    assign rcol_eff = drain_close ? '0 : rcol_reg;
    assign rbank    = drain_close ? wbank_reg : ~wbank_reg;

    assign emit     = pend_eff != '0;
    assign last     = (CNT_W'(rcol_eff) + CNT_W'(1)) >= pend_eff;
    assign idx_full = pend_eff - CNT_W'(1) - CNT_W'(rcol_eff);
    assign rd_idx   = mirror_reg ? idx_full[COL_W-1:0] : rcol_eff;
    assign wr_en    = accept && (s_mode == rpe_pkg::MODE_PIXEL);

    always_comb begin
        wcol_next  = wcol_reg;
        wbank_next = wbank_reg;
        pend_next  = pend_reg;
        rcol_next  = rcol_reg;
        if (accept) begin
            if (drain_close) begin
                wbank_next = ~wbank_reg;
                wcol_next  = '0;
            end
            if (emit) begin
                if (last) begin
                    pend_next = '0;
                    rcol_next = '0;
                end else begin
                    pend_next = pend_eff;
                    rcol_next = rcol_eff + COL_W'(1);
                end
            end
            if (s_mode == rpe_pkg::MODE_PIXEL) begin
                // A closing row replaces whatever is left of the pending one.
                if (wcol_inc >= eff_width) begin
                    pend_next  = wcol_inc;
                    rcol_next  = '0;
                    wbank_next = ~wbank_reg;
                    wcol_next  = '0;
                end else begin
                    wcol_next  = wcol_inc[COL_W-1:0];
                end
            end
        end
    end

    always_comb begin
        if (accept) begin
            p1_valid_next = emit;
        end else if (out_adv) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcol_reg     <= '0;
            wbank_reg    <= 1'b0;
            pend_reg     <= '0;
            rcol_reg     <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            wcol_reg     <= wcol_next;
            wbank_reg    <= wbank_next;
            pend_reg     <= pend_next;
            rcol_reg     <= rcol_next;
            p1_valid_reg <= p1_valid_next;
            if (out_adv) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            p1_last_reg <= last;
        end
        if (out_adv && p1_valid_reg) begin
            m_pix_reg  <= rd_data;
            m_last_reg <= p1_last_reg;
        end
    end

    rpe_line_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (rpe_pkg::PIX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr ({wbank_reg, wcol_reg}),
        .wr_data (fx_pixel),
        .rd_en   (accept && emit),
        .rd_addr ({rbank, rd_idx}),
        .rd_data (rd_data)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_pix_reg[rpe_pkg::CH_W-1:0];
    assign m_out_green = m_pix_reg[2*rpe_pkg::CH_W-1:rpe_pkg::CH_W];
    assign m_out_blue  = m_pix_reg[3*rpe_pkg::CH_W-1:2*rpe_pkg::CH_W];
    assign m_row_end   = m_last_reg;

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pend_reg) <= 32'(MAX_ROW_WIDTH))
        else $error("pending row longer than the line store bank");

    a_rcol_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != '0) |-> (CNT_W'(rcol_reg) < pend_reg))
        else $error("read column past the end of the pending row");

    a_wcol_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wcol_reg) < 32'(MAX_ROW_WIDTH))
        else $error("write column outside the bank");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while the read word cannot move on");

    a_read_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit) |=> p1_valid_reg)
        else $error("line store read not followed by a held word");

endmodule

FILE: rtl/rpe_pixel_fx.sv
module rpe_pixel_fx (
    input  rpe_pkg::fx_cfg_t              cfg,
    input  logic [rpe_pkg::CH_W-1:0]      red,
    input  logic [rpe_pkg::CH_W-1:0]      green,
    input  logic [rpe_pkg::CH_W-1:0]      blue,
    output logic [rpe_pkg::PIX_W-1:0]     pixel
);

    logic [rpe_pkg::SUM_W-1:0] sum;
    logic [rpe_pkg::CH_W-1:0]  avg;
    logic [rpe_pkg::CH_W-1:0]  ch [3];

    assign sum = rpe_pkg::SUM_W'(red) + rpe_pkg::SUM_W'(green) + rpe_pkg::SUM_W'(blue);
    assign avg = rpe_pkg::div3(sum);

    always_comb begin
        if (cfg.greyscale_on) begin
            ch[0] = avg;
            ch[1] = avg;
            ch[2] = avg;
        end else begin
            ch[0] = red;
            ch[1] = green;
            ch[2] = blue;
        end
        for (int i = 0; i < 3; i++) begin
            if (cfg.negate_mask[i]) begin
                ch[i] = ~ch[i];
            end
            if (cfg.flatten_mask[i]) begin
                ch[i] = '0;
            end
            // Above 127 is exactly the top bit being set.
            if (cfg.contrast_on) begin
                ch[i] = {rpe_pkg::CH_W{ch[i][rpe_pkg::CH_W-1]}};
            end
        end
    end

    assign pixel = {ch[2], ch[1], ch[0]};

endmodule

FILE: rtl/rpe_line_mem.sv
module rpe_line_mem #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 24
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read so a stalled word stays put.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: dv/rgb_pixel_effects_with_row_mirror_test.sv
`timescale 1ns / 1ps

module rgb_pixel_effects_with_row_mirror_test;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_LIMIT = 20000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 12;

    class effects_scoreboard;
        localparam int ROW_MAX = rpe_pkg::MAX_ROW_WIDTH_DEF;
        localparam logic [rpe_pkg::CH_W-1:0] CH_FULL = 8'd255;
        localparam logic [rpe_pkg::CH_W-1:0] CH_HALF = 8'd127;

        typedef struct packed {
            logic [rpe_pkg::CH_W-1:0] red;
            logic [rpe_pkg::CH_W-1:0] green;
            logic [rpe_pkg::CH_W-1:0] blue;
            logic                     row_end;
        } pixel_out_t;

        logic [rpe_pkg::PIX_W-1:0] line_bank [2*ROW_MAX];
        int unsigned      wr_col;
        int unsigned      rd_col;
        int unsigned      pend_len;
        bit               wr_bank;

        bit               grey_en;
        bit               mirror_en;
        bit               contrast_en;
        bit [2:0]         negate_bits;
        bit [2:0]         flatten_bits;
        bit [rpe_pkg::RW_W-1:0] width_reg;

        pixel_out_t       expected_pixels[$];
        int               errors;

        function void reset_state();
            wr_col       = 0;
            rd_col       = 0;
            pend_len     = 0;
            wr_bank      = 1'b0;
            grey_en      = 1'b0;
            mirror_en    = 1'b0;
            contrast_en  = 1'b0;
            negate_bits  = '0;
            flatten_bits = '0;
            width_reg    = rpe_pkg::ROW_WIDTH_RESET;
            errors       = 0;
            expected_pixels.delete();
        endfunction

        function void set_register(rpe_pkg::cfg_reg_t idx,
                                   logic [rpe_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rpe_pkg::REG_GREYSCALE: grey_en      = data[0];
                rpe_pkg::REG_MIRROR:    mirror_en    = data[0];
                rpe_pkg::REG_NEGATE:    negate_bits  = data[2:0];
                rpe_pkg::REG_FLATTEN:   flatten_bits = data[2:0];
                rpe_pkg::REG_CONTRAST:  contrast_en  = data[0];
                rpe_pkg::REG_ROW_WIDTH: width_reg    = data[rpe_pkg::RW_W-1:0];
                default: ;
            endcase
        endfunction

        function bit has_backlog();
            return (pend_len != 0) || (wr_col != 0);
        endfunction

        // Reads the next pixel of the completed row from the bank not being written.
        function void emit_row_pixel();
            int unsigned               col;
            logic [rpe_pkg::PIX_W-1:0] word;
            pixel_out_t                res;
            if (pend_len == 0)
                return;
            col = mirror_en ? (pend_len - 1 - rd_col) : rd_col;
            word = line_bank[(wr_bank ? 0 : ROW_MAX) + col];
            res.red     = word[rpe_pkg::CH_W-1:0];
            res.green   = word[2*rpe_pkg::CH_W-1:rpe_pkg::CH_W];
            res.blue    = word[3*rpe_pkg::CH_W-1:2*rpe_pkg::CH_W];
            res.row_end = (rd_col + 1 >= pend_len);
            expected_pixels.push_back(res);
            if (res.row_end) begin
                pend_len = 0;
                rd_col   = 0;
            end else begin
                rd_col++;
            end
        endfunction

        // A newly closed row replaces whatever is left of the previous one.
        function void close_row(int unsigned len);
            pend_len = len;
            rd_col   = 0;
            wr_bank  = !wr_bank;
            wr_col   = 0;
        endfunction

        function void take_item(logic mode, logic [rpe_pkg::CH_W-1:0] r,
                                logic [rpe_pkg::CH_W-1:0] g, logic [rpe_pkg::CH_W-1:0] b);
            logic [rpe_pkg::CH_W-1:0]  chan [3];
            logic [rpe_pkg::SUM_W-1:0] sum;
            int unsigned               eff_width;
            int                        i;
            if (mode == rpe_pkg::MODE_DRAIN) begin
                if (pend_len == 0 && wr_col > 0)
                    close_row(wr_col);
                emit_row_pixel();
                return;
            end
            chan[0] = r;
            chan[1] = g;
            chan[2] = b;
            if (grey_en) begin
                sum = rpe_pkg::SUM_W'(r) + rpe_pkg::SUM_W'(g) + rpe_pkg::SUM_W'(b);
                for (i = 0; i < 3; i++)
                    chan[i] = rpe_pkg::CH_W'(sum / 3);
            end
            for (i = 0; i < 3; i++) begin
                if (negate_bits[i])
                    chan[i] = CH_FULL - chan[i];
                if (flatten_bits[i])
                    chan[i] = '0;
                if (contrast_en)
                    chan[i] = (chan[i] > CH_HALF) ? CH_FULL : '0;
            end
            if (width_reg == 0)
                eff_width = 1;
            else if (32'(width_reg) > ROW_MAX)
                eff_width = ROW_MAX;
            else
                eff_width = 32'(width_reg);
            emit_row_pixel();
            line_bank[(wr_bank ? ROW_MAX : 0) + wr_col] = {chan[2], chan[1], chan[0]};
            if (wr_col + 1 >= eff_width)
                close_row(wr_col + 1);
            else
                wr_col++;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_pixel(logic [rpe_pkg::CH_W-1:0] r, logic [rpe_pkg::CH_W-1:0] g,
                         logic [rpe_pkg::CH_W-1:0] b, logic last);
            pixel_out_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected word r%0d g%0d b%0d end%0b", r, g, b, last));
                return;
            end
            want = expected_pixels.pop_front();
            if (r !== want.red || g !== want.green || b !== want.blue ||
                last !== want.row_end)
                report($sformatf("got r%0d g%0d b%0d end%0b, want r%0d g%0d b%0d end%0b",
                                 r, g, b, last, want.red, want.green, want.blue,
                                 want.row_end));
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rpe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rpe_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_mode;
    logic [rpe_pkg::CH_W-1:0]       s_in_red;
    logic [rpe_pkg::CH_W-1:0]       s_in_green;
    logic [rpe_pkg::CH_W-1:0]       s_in_blue;
    logic                           m_valid;
    logic                           m_ready;
    logic [rpe_pkg::CH_W-1:0]       m_out_red;
    logic [rpe_pkg::CH_W-1:0]       m_out_green;
    logic [rpe_pkg::CH_W-1:0]       m_out_blue;
    logic                           m_row_end;

    effects_scoreboard sb;
    int  send_idle_pct = 21;
    int  recv_idle_pct = 62;
    bit  hold_request  = 1'b0;
    int  cycle_count   = 0;

    rgb_pixel_effects_with_row_mirror DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_row_end   (m_row_end)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_out_red, m_out_green, m_out_blue, m_row_end);
    end

    // Called and returning at a falling edge; valid is left high for the caller.
    task automatic write_reg(rpe_pkg::cfg_reg_t idx, logic [rpe_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, data);
        @(negedge aclk);
    endtask

    // Upper data bits of the flag and mask writes carry noise; the block must ignore them.
    task automatic program_fx(bit grey, bit mirror, bit [2:0] neg, bit [2:0] flat,
                              bit contrast, bit [rpe_pkg::RW_W-1:0] width);
        write_reg(rpe_pkg::REG_GREYSCALE, {10'($urandom), grey});
        write_reg(rpe_pkg::REG_MIRROR,    {10'($urandom), mirror});
        write_reg(rpe_pkg::REG_NEGATE,    {8'($urandom), neg});
        write_reg(rpe_pkg::REG_FLATTEN,   {8'($urandom), flat});
        write_reg(rpe_pkg::REG_CONTRAST,  {10'($urandom), contrast});
        write_reg(rpe_pkg::REG_ROW_WIDTH, width);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic mode, logic [rpe_pkg::CH_W-1:0] r,
                             logic [rpe_pkg::CH_W-1:0] g, logic [rpe_pkg::CH_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_in_red   <= r;
        s_in_green <= g;
        s_in_blue  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.take_item(mode, r, g, b);
        @(negedge aclk);
    endtask

    task automatic send_drain();
        send_item(rpe_pkg::MODE_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Waits until every expected word is out, then lets the pipeline go quiet.
    task automatic settle();
        int waited;
        waited = 0;
        while (sb.expected_pixels.size() != 0 && waited < SETTLE_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (sb.expected_pixels.size() != 0) begin
            sb.report($sformatf("%0d expected words never arrived",
                                sb.expected_pixels.size()));
            sb.expected_pixels.delete();
        end
        repeat (4) @(negedge aclk);
    endtask

    // A phase that may not flush leaves its pending row for the next width to cut short.
    task automatic run_phase(int n_items, int drain_pct, bit [rpe_pkg::RW_W-1:0] width,
                             bit flush_ok);
        program_fx(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 1) ? 3'($urandom) : 3'd0,
                   ($urandom_range(0, 4) < 2) ? 3'($urandom) : 3'd0,
                   ($urandom_range(0, 3) == 0), width);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < drain_pct)
                send_drain();
            else
                send_item(rpe_pkg::MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        if (flush_ok && $urandom_range(0, 1)) begin
            while (sb.has_backlog())
                send_drain();
        end
        s_valid <= 1'b0;
        settle();
    endtask

    initial begin
        int                     phase;
        bit [rpe_pkg::RW_W-1:0] width;
        sb = new();
        sb.reset_state();
        aresetn    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= rpe_pkg::REG_GREYSCALE;
        cfg_data   <= '0;
        s_valid    <= 1'b0;
        s_mode     <= rpe_pkg::MODE_PIXEL;
        s_in_red   <= '0;
        s_in_green <= '0;
        s_in_blue  <= '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Mirrored row of four, then drains empty it; the last drain finds nothing.
        program_fx(1'b0, 1'b1, 3'b000, 3'b000, 1'b0, 11'd4);
        send_item(rpe_pkg::MODE_PIXEL, 8'd0, 8'd0, 8'd0);
        send_item(rpe_pkg::MODE_PIXEL, 8'd255, 8'd255, 8'd255);
        send_item(rpe_pkg::MODE_PIXEL, 8'd128, 8'd127, 8'd1);
        send_item(rpe_pkg::MODE_PIXEL, 8'd254, 8'd1, 8'd200);
        repeat (5) send_drain();
        s_valid <= 1'b0;
        settle();

        // Greyscale at the sum extremes with negation; a partial row closed by drains.
        program_fx(1'b1, 1'b0, 3'b101, 3'b000, 1'b0, 11'd3);
        send_item(rpe_pkg::MODE_PIXEL, 8'd255, 8'd255, 8'd255);
        send_item(rpe_pkg::MODE_PIXEL, 8'd255, 8'd255, 8'd254);
        send_item(rpe_pkg::MODE_PIXEL, 8'd1, 8'd1, 8'd0);
        send_item(rpe_pkg::MODE_PIXEL, 8'd0, 8'd255, 8'd0);
        send_item(rpe_pkg::MODE_PIXEL, 8'd9, 8'd9, 8'd9);
        repeat (3) send_drain();
        s_valid <= 1'b0;
        settle();

        // Width shrinks while a row is half read out: the rest of that row is dropped.
        program_fx(1'b0, 1'b0, 3'b010, 3'b100, 1'b1, 11'd4);
        send_item(rpe_pkg::MODE_PIXEL, 8'd200, 8'd100, 8'd128);
        send_item(rpe_pkg::MODE_PIXEL, 8'd127, 8'd128, 8'd0);
        send_item(rpe_pkg::MODE_PIXEL, 8'd10, 8'd250, 8'd60);
        send_item(rpe_pkg::MODE_PIXEL, 8'd255, 8'd0, 8'd255);
        send_item(rpe_pkg::MODE_PIXEL, 8'd77, 8'd33, 8'd199);
        s_valid <= 1'b0;
        settle();
        write_reg(rpe_pkg::REG_ROW_WIDTH, 11'd1);
        cfg_valid <= 1'b0;
        send_item(rpe_pkg::MODE_PIXEL, 8'd5, 8'd250, 8'd129);
        repeat (2) send_drain();
        s_valid <= 1'b0;
        settle();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == NUM_PHASES / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 21;
            end
            if (phase == 2 * NUM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: width = 11'd0;
                2: width = 11'd4;
                3: width = 11'd2047;
                4: width = 11'd3;
                7: width = 11'd1024;
                default: width = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(17, 64))
                                                             : 11'($urandom_range(1, 16));
            endcase
            if (phase == 2)
                hold_request = 1'b1;
            // One full-width row, then the narrower width of the next phase cuts it off.
            if (phase == 3)
                run_phase(1030, 0, width, 1'b0);
            else if (phase == 2)
                run_phase(80, 12, width, 1'b1);
            else
                run_phase(int'($urandom_range(8, 20)), 12, width, 1'b1);
        end

        settle();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rpe_pkg.sv
rtl/rpe_pixel_fx.sv
rtl/rpe_line_mem.sv
rtl/rgb_pixel_effects_with_row_mirror.sv
dv/rgb_pixel_effects_with_row_mirror_test.sv
